// ===== rtl/core/stride_aligned_bump_allocator_top_macros.svh =====
// Assertion macros for the stride aligned bump allocator.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef STRIDE_ALIGNED_BUMP_ALLOCATOR_TOP_MACROS_SVH
`define STRIDE_ALIGNED_BUMP_ALLOCATOR_TOP_MACROS_SVH

// Implication checked in the same cycle, outside of reset.
`define SBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle, outside of reset.
`define SBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sba_pkg.sv =====
// Shared types and constants for the stride aligned bump allocator.
// No dependencies; imported by sba_div and stride_aligned_bump_allocator_top.
package sba_pkg;

	localparam int KIND_W     = 1;
	localparam int COUNT_W    = 16;
	localparam int STRIDE_W   = 10;
	localparam int SIZE_W     = 24;
	localparam int OUT_W      = 24;
	localparam int STATUS_W   = 2;
	localparam int PROD_W     = COUNT_W + STRIDE_W;

	localparam int DEFAULT_OFFSET_BITS = 24;
	localparam logic [SIZE_W-1:0] DEFAULT_REGION_BYTES =
		SIZE_W'(5 * 1024 * 1024 + (512 + 256 + 64 + 128 + 64) * 1024);

	localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
	localparam logic [KIND_W-1:0] KIND_CLEAN = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_NO_SPACE    = 2'd1,
		ST_ZERO_STRIDE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_RESET  = 2'd0,
		PH_ARMED  = 2'd1,
		PH_REWIND = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_CHECK,
		S_FIN
	} seq_state_t;

	// Result of the remainder unit: done pulses for one cycle with rem valid.
	typedef struct packed {
		logic                done;
		logic [STRIDE_W-1:0] rem;
	} div_res_t;

endpackage

// ===== rtl/core/sba_div.sv =====
// Bit-serial remainder unit: computes dividend modulo divisor, one bit per cycle.
// Depends on sba_pkg.
module sba_div #(
	parameter int OFFSET_BITS = sba_pkg::DEFAULT_OFFSET_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [OFFSET_BITS-1:0]       dividend,
	input  logic [sba_pkg::STRIDE_W-1:0] divisor,
	output sba_pkg::div_res_t            res
);
	import sba_pkg::*;

	localparam int CNT_W = $clog2(OFFSET_BITS);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [OFFSET_BITS-1:0] dvd_q;
	logic [STRIDE_W-1:0]    rem_q;
	logic [STRIDE_W:0]      trial;
	logic [STRIDE_W:0]      diff;
	logic                   fits;

	// Shift the next dividend bit into the partial remainder and subtract if it fits.
	assign trial = {rem_q, dvd_q[OFFSET_BITS-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(OFFSET_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[OFFSET_BITS-2:0], 1'b0};
			rem_q <= fits ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.rem  = rem_q;

endmodule

// ===== rtl/core/stride_aligned_bump_allocator_top.sv =====
// Stride aligned bump allocator: top level with sequencer, state and output register.
// Depends on sba_pkg, sba_div and stride_aligned_bump_allocator_top_macros.svh.
//
// Usage. Input words arrive on in_valid / in_stall and carry kind, vertex_count
// and stride. Each input word produces exactly one output word on
// out_valid / out_stall with status, offset and next_offset. A word moves on a
// rising edge where valid is high and stall is low.
// An allocate word rounds the next-free offset up to a multiple of the stride
// with a bit-serial remainder unit that handles one offset bit per cycle, then
// multiplies count by stride, adds and checks the end against buffer_size.
// An allocate word passes from S_DIV, where the remainder loop runs, through S_CHECK to
// S_FIN and then into the output register; clean words and zero-stride allocates go
// straight to S_FIN. The next word can be accepted in the cycle after a result is loaded.
// One word is in flight at a time: in_stall is high from acceptance until the
// result has been moved into the output register. A finished result waits in
// the sequencer while the output register is held by out_stall, so a stalled
// receiver stalls the input side only once both are full; a new word may be
// accepted while the previous result still waits at the output.
// Reset clears next-free, the fixed mark and the clean phase and loads buffer_size with
// its default. The user must let cfg_we write buffer_size only while idle; the block itself does not enforce it.
`include "stride_aligned_bump_allocator_top_macros.svh"

module stride_aligned_bump_allocator_top #(
	parameter int OFFSET_BITS = sba_pkg::DEFAULT_OFFSET_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration
	input  logic                         cfg_we,
	input  logic [sba_pkg::SIZE_W-1:0]   cfg_wdata,
	// Input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [sba_pkg::KIND_W-1:0]   kind,
	input  logic [sba_pkg::COUNT_W-1:0]  vertex_count,
	input  logic [sba_pkg::STRIDE_W-1:0] stride,
	// Output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [sba_pkg::STATUS_W-1:0] status,
	output logic [sba_pkg::OUT_W-1:0]    offset,
	output logic [sba_pkg::OUT_W-1:0]    next_offset
);
	import sba_pkg::*;

	// Wide enough for a rounded start plus the largest count times stride.
	localparam int END_W = OFFSET_BITS + PROD_W + 1;
	localparam logic [END_W-1:0] OFFSET_MAX = END_W'({OFFSET_BITS{1'b1}});

	seq_state_t state_q, state_d;

	logic [SIZE_W-1:0]      buffer_size_q;
	logic [OFFSET_BITS-1:0] next_free_q;
	logic [OFFSET_BITS-1:0] fixed_mark_q;
	phase_t                 phase_q;

	logic [COUNT_W-1:0]     count_q;
	logic [STRIDE_W-1:0]    stride_q;
	logic [END_W-1:0]       start_q;
	logic [PROD_W-1:0]      prod_q;

	// Result staged by the sequencer and the state it commits.
	status_t                res_status_q;
	logic [OFFSET_BITS-1:0] res_offset_q;
	logic [OFFSET_BITS-1:0] res_nf_q;
	logic [OFFSET_BITS-1:0] res_mark_q;
	phase_t                 res_phase_q;

	logic                   out_valid_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic [OUT_W-1:0]       out_offset_q;
	logic [OUT_W-1:0]       out_next_q;

	logic                   in_fire;
	logic                   slot_free;
	logic                   div_start;
	logic                   fin_load;
	logic                   direct;
	div_res_t               div_res;
	logic [END_W-1:0]       end_sum;
	logic                   no_space;
	logic [STRIDE_W-1:0]    pad;

	// The divisor comes from the captured stride, since the input port may
	// change once the word has been accepted.
	sba_div #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (next_free_q),
		.divisor  (stride_q),
		.res      (div_res)
	);

	assign in_fire   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	// Clean words and zero strides need no arithmetic and go straight to commit.
	assign direct    = (kind == KIND_CLEAN) || (stride == '0);

	// Bytes needed to reach the next multiple of the stride.
	assign pad     = (div_res.rem == '0) ? '0 : stride_q - div_res.rem;
	assign end_sum = start_q + END_W'(prod_q);
	assign no_space = (end_sum > END_W'(buffer_size_q)) || (end_sum > OFFSET_MAX);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = direct ? S_FIN : S_DIV;
				end
			end
			S_DIV: begin
				if (div_res.done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		fin_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall  = 1'b0;
				div_start = in_valid && !direct;
			end
			S_FIN: begin
				fin_load = slot_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			buffer_size_q <= DEFAULT_REGION_BYTES;
			next_free_q   <= '0;
			fixed_mark_q  <= '0;
			phase_q       <= PH_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				buffer_size_q <= cfg_wdata;
			end
			// The item's effect on the allocator state lands when its result leaves.
			if (fin_load) begin
				next_free_q  <= res_nf_q;
				fixed_mark_q <= res_mark_q;
				phase_q      <= res_phase_q;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath and staged results.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			count_q      <= vertex_count;
			stride_q     <= stride;
			res_status_q <= ST_OK;
			res_offset_q <= '0;
			res_nf_q     <= next_free_q;
			res_mark_q   <= fixed_mark_q;
			res_phase_q  <= phase_q;
			if (kind == KIND_CLEAN) begin
				unique case (phase_q)
					PH_RESET: begin
						res_phase_q <= PH_ARMED;
					end
					PH_ARMED: begin
						res_mark_q  <= next_free_q;
						res_phase_q <= PH_REWIND;
					end
					default: begin
						res_nf_q <= fixed_mark_q;
					end
				endcase
			end else if (stride == '0) begin
				res_status_q <= ST_ZERO_STRIDE;
			end
		end
		if (state_q == S_DIV && div_res.done) begin
			start_q <= END_W'(next_free_q) + END_W'(pad);
			prod_q  <= count_q * stride_q;
		end
		if (state_q == S_CHECK) begin
			if (no_space) begin
				res_status_q <= ST_NO_SPACE;
			end else begin
				res_offset_q <= OFFSET_BITS'(start_q);
				res_nf_q     <= OFFSET_BITS'(end_sum);
			end
		end
		if (fin_load) begin
			out_status_q <= res_status_q;
			out_offset_q <= OUT_W'(res_offset_q);
			out_next_q   <= OUT_W'(res_nf_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign offset      = out_offset_q;
	assign next_offset = out_next_q;

	// An accepted word always leaves the sequencer busy in the next cycle.
	`SBA_ASSERT_NEXT(a_busy_after_accept, in_fire, state_q != S_IDLE, "accepted word left no work")
	// The remainder unit finishes only while the sequencer waits for it.
	`SBA_ASSERT_NOW(a_div_done_in_div, div_res.done, state_q == S_DIV, "stray remainder done")
	// Error results never grant an offset.
	`SBA_ASSERT_NOW(a_err_zero_offset, out_valid && status != ST_OK, offset == '0, "error with offset")
	// The fixed mark moves only on the clean that leaves the armed phase.
	`SBA_ASSERT_NEXT(a_mark_move, fin_load && res_phase_q != PH_REWIND, $stable(fixed_mark_q) || $past(phase_q) == PH_ARMED, "fixed mark moved outside the arming clean")

endmodule
